// ----- rtl/core/rpn_stack_calculator_unit_defines.svh -----
// Assertion macros used by the port checker of the calculator.
`ifndef RPN_STACK_CALCULATOR_UNIT_DEFINES_SVH
`define RPN_STACK_CALCULATOR_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RPNC_ASSERT_IMP(name, ck, rn, ante, cons) \
    name: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("rpnc assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define RPNC_ASSERT_NXT(name, ck, rn, ante, cons) \
    name: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("rpnc assertion failed");

`endif

// ----- rtl/core/rpnc_pkg.sv -----
// ----------------------------------------------------------------------------
// rpnc_pkg
// Types and constants shared by the stack calculator controller and datapath.
// ----------------------------------------------------------------------------
package rpnc_pkg;

    localparam int DATA_W      = 48;
    localparam int MAX_RESULTS = 64;

    localparam logic [DATA_W-1:0] VAL_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic [DATA_W-1:0] VAL_MIN = {1'b1, {(DATA_W-1){1'b0}}};

    typedef enum logic [3:0] {
        REQ_PUSH    = 4'd0,
        REQ_ADD     = 4'd1,
        REQ_SUB     = 4'd2,
        REQ_MUL     = 4'd3,
        REQ_DIV     = 4'd4,
        REQ_REM     = 4'd5,
        REQ_ENDLINE = 4'd6,
        REQ_PEEK    = 4'd7,
        REQ_DUP     = 4'd8,
        REQ_SWAP    = 4'd9,
        REQ_CLEAR   = 4'd10,
        REQ_DUMP    = 4'd11
    } req_t;

    typedef enum logic [2:0] {
        KIND_LINE  = 3'd0,
        KIND_PEEK  = 3'd1,
        KIND_DUMP  = 3'd2,
        KIND_EMPTY = 3'd3,
        KIND_ERROR = 3'd4
    } kind_t;

    typedef enum logic [2:0] {
        ERR_NONE     = 3'd0,
        ERR_ZERO_DIV = 3'd1,
        ERR_FULL     = 3'd2,
        ERR_EMPTY    = 3'd3,
        ERR_FEW      = 3'd4,
        ERR_UNKNOWN  = 3'd5
    } err_t;

    typedef enum logic [2:0] {
        ALU_ADD,
        ALU_SUB,
        ALU_MUL,
        ALU_DIV,
        ALU_REM
    } alu_op_t;

    typedef enum logic [1:0] {
        ADDR_SP,
        ADDR_TOP,
        ADDR_SECOND,
        ADDR_IDX
    } addr_sel_t;

    typedef enum logic [1:0] {
        WD_OPERAND,
        WD_RDATA,
        WD_X,
        WD_ALU
    } wd_sel_t;

    typedef enum logic [1:0] {
        EV_ZERO,
        EV_RDATA,
        EV_Y
    } ev_sel_t;

    typedef enum logic [1:0] {
        SP_HOLD,
        SP_INC,
        SP_DEC,
        SP_CLR
    } sp_op_t;

    typedef enum logic [1:0] {
        SUP_HOLD,
        SUP_SET,
        SUP_CLR
    } sup_op_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_DISPATCH,
        S_POP_Y,
        S_POP_Y_WAIT,
        S_Y_READY,
        S_POP_X,
        S_POP_X_WAIT,
        S_ALU_GO,
        S_ALU_WAIT,
        S_PEEK_EMIT,
        S_DUP_WR,
        S_SWAP_RD2,
        S_SWAP_WR1,
        S_SWAP_WR2,
        S_DUMP_RD,
        S_DUMP_EMIT
    } ctrl_state_t;

    typedef struct packed {
        logic      load_in;
        logic      mem_re;
        addr_sel_t rd_sel;
        logic      mem_we;
        addr_sel_t wr_sel;
        wd_sel_t   wd_sel;
        sp_op_t    sp_op;
        sup_op_t   sup_op;
        logic      ld_x;
        logic      ld_y;
        logic      clr_x;
        logic      clr_y;
        logic      idx_clr;
        logic      idx_inc;
        logic      alu_start;
        alu_op_t   alu_op;
        logic      emit;
        kind_t     kind;
        err_t      code;
        ev_sel_t   ev_sel;
        logic      last;
    } dp_cmd_t;

    typedef struct packed {
        logic sp_zero;
        logic sp_full;
        logic sp_gt1;
        logic sup;
        logic y_zero;
        logic y_int_zero;
        logic out_busy;
        logic alu_done;
        logic idx_last;
    } dp_status_t;

endpackage

// ----- rtl/core/rpnc_alu.sv -----
// ----------------------------------------------------------------------------
// rpnc_alu
// Saturating fixed-point add, subtract, multiply, divide and integer remainder.
// Multiply takes four 24x24 partial products; divide and remainder share one
// restoring divider that retires one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rpnc_alu
    import rpnc_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  alu_op_t                  op,
    input  logic signed [DATA_W-1:0] x,
    input  logic signed [DATA_W-1:0] y,
    output logic                     done,
    output logic        [DATA_W-1:0] result
);

    localparam int N  = DATA_W + FRAC_BITS;
    localparam int CW = $clog2(N + 1);
    localparam int PW = 2 * DATA_W;
    localparam int HW = DATA_W / 2;

    alu_op_t                  op_reg;
    logic signed [DATA_W-1:0] xs_reg;
    logic signed [DATA_W-1:0] ys_reg;
    logic                     neg_reg;
    logic                     negx_reg;
    logic        [DATA_W-1:0] ma_reg;
    logic        [DATA_W-1:0] mb_reg;
    logic        [PW-1:0]     acc_reg;
    logic        [1:0]        step_reg;
    logic        [N-1:0]      dq_reg;
    logic        [DATA_W-1:0] rem_reg;
    logic        [DATA_W-1:0] dv_reg;
    logic        [CW-1:0]     cnt_reg;
    logic                     mul_run_reg;
    logic                     div_run_reg;
    logic                     fin_reg;
    logic                     done_reg;
    logic        [DATA_W-1:0] res_reg;

    logic        [DATA_W-1:0] mx;
    logic        [DATA_W-1:0] my;
    logic        [HW-1:0]     a_half;
    logic        [HW-1:0]     b_half;
    logic        [DATA_W-1:0] pp;
    logic        [PW-1:0]     pp_shift;
    logic        [DATA_W:0]   trial;
    logic                     ge;
    logic signed [DATA_W:0]   sum;
    logic                     hi_nz;
    logic        [DATA_W-2:0] qlo;
    logic        [DATA_W-1:0] rv;
    logic        [DATA_W-1:0] fin_val;

    assign mx = x[DATA_W-1] ? DATA_W'(-x) : DATA_W'(x);
    assign my = y[DATA_W-1] ? DATA_W'(-y) : DATA_W'(y);

    assign a_half   = step_reg[0] ? ma_reg[DATA_W-1:HW] : ma_reg[HW-1:0];
    assign b_half   = step_reg[1] ? mb_reg[DATA_W-1:HW] : mb_reg[HW-1:0];
    assign pp       = a_half * b_half;
    assign pp_shift = (PW'(pp) << (step_reg[0] ? HW : 0)) << (step_reg[1] ? HW : 0);

    assign trial = {rem_reg, dq_reg[N-1]};
    assign ge    = trial >= {1'b0, dv_reg};

    always_comb
    begin
        sum   = (op_reg == ALU_SUB) ? ((DATA_W+1)'(xs_reg) - (DATA_W+1)'(ys_reg))
                                    : ((DATA_W+1)'(xs_reg) + (DATA_W+1)'(ys_reg));
        hi_nz = 1'b0;
        qlo   = '0;
        rv    = rem_reg << FRAC_BITS;
        case (op_reg)
            ALU_MUL:
            begin
                hi_nz = |acc_reg[PW-1:FRAC_BITS+DATA_W-1];
                qlo   = acc_reg[FRAC_BITS+DATA_W-2:FRAC_BITS];
            end
            default:
            begin
                hi_nz = |dq_reg[N-1:DATA_W-1];
                qlo   = dq_reg[DATA_W-2:0];
            end
        endcase
        case (op_reg)
            ALU_ADD, ALU_SUB:
            begin
                if (sum[DATA_W] != sum[DATA_W-1])
                    fin_val = sum[DATA_W] ? VAL_MIN : VAL_MAX;
                else
                    fin_val = sum[DATA_W-1:0];
            end
            ALU_REM:
                fin_val = negx_reg ? DATA_W'(-rv) : rv;
            default:
            begin
                if (hi_nz)
                    fin_val = neg_reg ? VAL_MIN : VAL_MAX;
                else
                    fin_val = neg_reg ? DATA_W'(-{1'b0, qlo}) : {1'b0, qlo};
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mul_run_reg <= 1'b0;
            div_run_reg <= 1'b0;
            fin_reg     <= 1'b0;
            done_reg    <= 1'b0;
            step_reg    <= '0;
            cnt_reg     <= '0;
        end
        else if (start)
        begin
            done_reg    <= 1'b0;
            step_reg    <= '0;
            cnt_reg     <= CW'(N);
            mul_run_reg <= (op == ALU_MUL);
            div_run_reg <= (op == ALU_DIV) || (op == ALU_REM);
            fin_reg     <= (op == ALU_ADD) || (op == ALU_SUB);
        end
        else
        begin
            if (mul_run_reg)
            begin
                step_reg <= step_reg + 2'd1;
                if (step_reg == 2'd3)
                begin
                    mul_run_reg <= 1'b0;
                    fin_reg     <= 1'b1;
                end
            end
            if (div_run_reg)
            begin
                cnt_reg <= cnt_reg - CW'(1);
                if (cnt_reg == CW'(1))
                begin
                    div_run_reg <= 1'b0;
                    fin_reg     <= 1'b1;
                end
            end
            if (fin_reg)
            begin
                fin_reg  <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            op_reg   <= op;
            xs_reg   <= x;
            ys_reg   <= y;
            neg_reg  <= x[DATA_W-1] ^ y[DATA_W-1];
            negx_reg <= x[DATA_W-1];
            ma_reg   <= mx;
            mb_reg   <= my;
            acc_reg  <= '0;
            rem_reg  <= '0;
            // Remainder works on the integer parts only.
            dq_reg   <= (op == ALU_REM) ? N'(mx >> FRAC_BITS) : (N'(mx) << FRAC_BITS);
            dv_reg   <= (op == ALU_REM) ? (my >> FRAC_BITS) : my;
        end
        else
        begin
            if (mul_run_reg)
                acc_reg <= acc_reg + pp_shift;
            if (div_run_reg)
            begin
                rem_reg <= ge ? DATA_W'(trial - {1'b0, dv_reg}) : trial[DATA_W-1:0];
                dq_reg  <= {dq_reg[N-2:0], ge};
            end
            if (fin_reg)
                res_reg <= fin_val;
        end
    end

    assign done   = done_reg;
    assign result = res_reg;

endmodule

// ----- rtl/core/rpnc_ctrl.sv -----
// ----------------------------------------------------------------------------
// rpnc_ctrl
// Command sequencer: decodes one item and steps the datapath through its
// pops, stack memory accesses, arithmetic and result emission.
// ----------------------------------------------------------------------------
module rpnc_ctrl
    import rpnc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [3:0] req_type,
    input  dp_status_t st,
    output dp_cmd_t    cmd
);

    ctrl_state_t state_reg;
    ctrl_state_t state_next;
    req_t        req_reg;
    logic        emit_ok;

    assign in_ready = (state_reg == S_IDLE);
    assign emit_ok  = !st.out_busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            req_reg   <= REQ_PUSH;
        end
        else
        begin
            state_reg <= state_next;
            if (in_valid && in_ready)
                req_reg <= req_t'(req_type);
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
                if (in_valid)
                    state_next = S_DISPATCH;
            S_DISPATCH:
            begin
                case (req_reg)
                    REQ_PUSH:
                        if (!st.sp_full || emit_ok)
                            state_next = S_IDLE;
                    REQ_ADD, REQ_SUB, REQ_MUL, REQ_DIV, REQ_REM:
                        state_next = S_POP_Y;
                    REQ_ENDLINE:
                        state_next = st.sup ? S_IDLE : S_POP_Y;
                    REQ_PEEK:
                        if (!st.sp_zero)
                            state_next = S_PEEK_EMIT;
                        else if (emit_ok)
                            state_next = S_IDLE;
                    REQ_DUP:
                        if (!st.sp_zero && !st.sp_full)
                            state_next = S_DUP_WR;
                        else if (emit_ok)
                            state_next = S_IDLE;
                    REQ_SWAP:
                        if (st.sp_gt1)
                            state_next = S_SWAP_RD2;
                        else if (emit_ok)
                            state_next = S_IDLE;
                    REQ_CLEAR:
                        state_next = S_IDLE;
                    REQ_DUMP:
                        if (!st.sp_zero)
                            state_next = S_DUMP_RD;
                        else if (emit_ok)
                            state_next = S_IDLE;
                    default:
                        if (emit_ok)
                            state_next = S_IDLE;
                endcase
            end
            S_POP_Y:
                if (!st.sp_zero)
                    state_next = S_POP_Y_WAIT;
                else if (emit_ok)
                    state_next = S_Y_READY;
            S_POP_Y_WAIT:
                state_next = S_Y_READY;
            S_Y_READY:
            begin
                case (req_reg)
                    REQ_ENDLINE:
                        if (emit_ok)
                            state_next = S_IDLE;
                    REQ_DIV:
                        if (!st.y_zero)
                            state_next = S_POP_X;
                        else if (emit_ok)
                            state_next = S_IDLE;
                    REQ_REM:
                        if (!st.y_int_zero)
                            state_next = S_POP_X;
                        else if (emit_ok)
                            state_next = S_IDLE;
                    default:
                        state_next = S_POP_X;
                endcase
            end
            S_POP_X:
                if (!st.sp_zero)
                    state_next = S_POP_X_WAIT;
                else if (emit_ok)
                    state_next = S_ALU_GO;
            S_POP_X_WAIT:
                state_next = S_ALU_GO;
            S_ALU_GO:
                state_next = S_ALU_WAIT;
            S_ALU_WAIT:
                if (st.alu_done)
                    state_next = S_IDLE;
            S_PEEK_EMIT:
                if (emit_ok)
                    state_next = S_IDLE;
            S_DUP_WR:
                state_next = S_IDLE;
            S_SWAP_RD2:
                state_next = S_SWAP_WR1;
            S_SWAP_WR1:
                state_next = S_SWAP_WR2;
            S_SWAP_WR2:
                state_next = S_IDLE;
            S_DUMP_RD:
                state_next = S_DUMP_EMIT;
            S_DUMP_EMIT:
                if (emit_ok)
                    state_next = st.idx_last ? S_IDLE : S_DUMP_RD;
            default:
                state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd = '0;
        case (req_reg)
            REQ_SUB: cmd.alu_op = ALU_SUB;
            REQ_MUL: cmd.alu_op = ALU_MUL;
            REQ_DIV: cmd.alu_op = ALU_DIV;
            REQ_REM: cmd.alu_op = ALU_REM;
            default: cmd.alu_op = ALU_ADD;
        endcase
        case (state_reg)
            S_IDLE:
                cmd.load_in = in_valid;
            S_DISPATCH:
            begin
                case (req_reg)
                    REQ_PUSH:
                        if (!st.sp_full)
                        begin
                            cmd.mem_we = 1'b1;
                            cmd.wr_sel = ADDR_SP;
                            cmd.wd_sel = WD_OPERAND;
                            cmd.sp_op  = SP_INC;
                        end
                        else if (emit_ok)
                        begin
                            cmd.emit = 1'b1;
                            cmd.kind = KIND_ERROR;
                            cmd.code = ERR_FULL;
                            cmd.last = 1'b1;
                        end
                    REQ_ADD, REQ_SUB, REQ_MUL, REQ_DIV, REQ_REM:
                        cmd.sup_op = SUP_HOLD;
                    REQ_ENDLINE:
                        cmd.sup_op = SUP_CLR;
                    REQ_PEEK:
                        if (!st.sp_zero)
                        begin
                            cmd.mem_re = 1'b1;
                            cmd.rd_sel = ADDR_TOP;
                            cmd.sup_op = SUP_SET;
                        end
                        else if (emit_ok)
                        begin
                            cmd.emit   = 1'b1;
                            cmd.kind   = KIND_ERROR;
                            cmd.code   = ERR_EMPTY;
                            cmd.last   = 1'b1;
                            cmd.sup_op = SUP_SET;
                        end
                    REQ_DUP:
                        if (!st.sp_zero && !st.sp_full)
                        begin
                            cmd.mem_re = 1'b1;
                            cmd.rd_sel = ADDR_TOP;
                            cmd.sup_op = SUP_SET;
                        end
                        else if (emit_ok)
                        begin
                            cmd.emit   = 1'b1;
                            cmd.kind   = KIND_ERROR;
                            cmd.code   = st.sp_zero ? ERR_EMPTY : ERR_FULL;
                            cmd.last   = 1'b1;
                            cmd.sup_op = SUP_SET;
                        end
                    REQ_SWAP:
                        if (st.sp_gt1)
                        begin
                            cmd.mem_re = 1'b1;
                            cmd.rd_sel = ADDR_TOP;
                            cmd.sup_op = SUP_SET;
                        end
                        else if (emit_ok)
                        begin
                            cmd.emit   = 1'b1;
                            cmd.kind   = KIND_ERROR;
                            cmd.code   = ERR_FEW;
                            cmd.last   = 1'b1;
                            cmd.sup_op = SUP_SET;
                        end
                    REQ_CLEAR:
                    begin
                        cmd.sp_op  = SP_CLR;
                        cmd.sup_op = SUP_SET;
                    end
                    REQ_DUMP:
                        if (!st.sp_zero)
                        begin
                            cmd.idx_clr = 1'b1;
                            cmd.sup_op  = SUP_SET;
                        end
                        else if (emit_ok)
                        begin
                            cmd.emit   = 1'b1;
                            cmd.kind   = KIND_EMPTY;
                            cmd.last   = 1'b1;
                            cmd.sup_op = SUP_SET;
                        end
                    default:
                        if (emit_ok)
                        begin
                            cmd.emit = 1'b1;
                            cmd.kind = KIND_ERROR;
                            cmd.code = ERR_UNKNOWN;
                            cmd.last = 1'b1;
                        end
                endcase
            end
            S_POP_Y:
                if (!st.sp_zero)
                begin
                    cmd.mem_re = 1'b1;
                    cmd.rd_sel = ADDR_TOP;
                    cmd.sp_op  = SP_DEC;
                end
                else if (emit_ok)
                begin
                    // More results always follow a failed first pop.
                    cmd.emit  = 1'b1;
                    cmd.kind  = KIND_ERROR;
                    cmd.code  = ERR_EMPTY;
                    cmd.clr_y = 1'b1;
                end
            S_POP_Y_WAIT:
                cmd.ld_y = 1'b1;
            S_Y_READY:
            begin
                case (req_reg)
                    REQ_ENDLINE:
                        if (emit_ok)
                        begin
                            cmd.emit   = 1'b1;
                            cmd.kind   = KIND_LINE;
                            cmd.ev_sel = EV_Y;
                            cmd.last   = 1'b1;
                        end
                    REQ_DIV, REQ_REM:
                        if (((req_reg == REQ_DIV) ? st.y_zero : st.y_int_zero) && emit_ok)
                        begin
                            cmd.emit = 1'b1;
                            cmd.kind = KIND_ERROR;
                            cmd.code = ERR_ZERO_DIV;
                            cmd.last = 1'b1;
                        end
                    default:
                        cmd.emit = 1'b0;
                endcase
            end
            S_POP_X:
                if (!st.sp_zero)
                begin
                    cmd.mem_re = 1'b1;
                    cmd.rd_sel = ADDR_TOP;
                    cmd.sp_op  = SP_DEC;
                end
                else if (emit_ok)
                begin
                    // The push that follows cannot fail, so this is the final result.
                    cmd.emit  = 1'b1;
                    cmd.kind  = KIND_ERROR;
                    cmd.code  = ERR_EMPTY;
                    cmd.last  = 1'b1;
                    cmd.clr_x = 1'b1;
                end
            S_POP_X_WAIT:
                cmd.ld_x = 1'b1;
            S_ALU_GO:
                cmd.alu_start = 1'b1;
            S_ALU_WAIT:
                if (st.alu_done)
                begin
                    cmd.mem_we = 1'b1;
                    cmd.wr_sel = ADDR_SP;
                    cmd.wd_sel = WD_ALU;
                    cmd.sp_op  = SP_INC;
                end
            S_PEEK_EMIT:
                if (emit_ok)
                begin
                    cmd.emit   = 1'b1;
                    cmd.kind   = KIND_PEEK;
                    cmd.ev_sel = EV_RDATA;
                    cmd.last   = 1'b1;
                end
            S_DUP_WR:
            begin
                cmd.mem_we = 1'b1;
                cmd.wr_sel = ADDR_SP;
                cmd.wd_sel = WD_RDATA;
                cmd.sp_op  = SP_INC;
            end
            S_SWAP_RD2:
            begin
                cmd.ld_x   = 1'b1;
                cmd.mem_re = 1'b1;
                cmd.rd_sel = ADDR_SECOND;
            end
            S_SWAP_WR1:
            begin
                cmd.mem_we = 1'b1;
                cmd.wr_sel = ADDR_TOP;
                cmd.wd_sel = WD_RDATA;
            end
            S_SWAP_WR2:
            begin
                cmd.mem_we = 1'b1;
                cmd.wr_sel = ADDR_SECOND;
                cmd.wd_sel = WD_X;
            end
            S_DUMP_RD:
            begin
                cmd.mem_re = 1'b1;
                cmd.rd_sel = ADDR_IDX;
            end
            S_DUMP_EMIT:
                if (emit_ok)
                begin
                    cmd.emit    = 1'b1;
                    cmd.kind    = KIND_DUMP;
                    cmd.ev_sel  = EV_RDATA;
                    cmd.last    = st.idx_last;
                    cmd.idx_inc = 1'b1;
                end
            default:
                cmd.emit = 1'b0;
        endcase
    end

endmodule

// ----- rtl/core/rpnc_datapath.sv -----
// ----------------------------------------------------------------------------
// rpnc_datapath
// Stack memory, stack pointer, operand registers, arithmetic unit and the
// output register that holds one result item for the consumer.
// ----------------------------------------------------------------------------
module rpnc_datapath
    import rpnc_pkg::*;
#(
    parameter int STACK_DEPTH = 64,
    parameter int FRAC_BITS   = 16
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  dp_cmd_t                  cmd,
    output dp_status_t               st,
    input  logic signed [DATA_W-1:0] operand_value,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic        [2:0]        result_kind,
    output logic        [2:0]        error_code,
    output logic signed [DATA_W-1:0] result_value,
    output logic                     last_of_run
);

    localparam int SP_W = $clog2(STACK_DEPTH + 1);
    localparam int AW   = $clog2(STACK_DEPTH);

    logic [DATA_W-1:0] mem [STACK_DEPTH];

    logic [SP_W-1:0]   sp_reg;
    logic              sup_reg;
    logic [AW-1:0]     idx_reg;
    logic [DATA_W-1:0] operand_reg;
    logic [DATA_W-1:0] x_reg;
    logic [DATA_W-1:0] y_reg;
    logic [DATA_W-1:0] rdata_reg;
    logic              out_valid_reg;
    kind_t             kind_reg;
    err_t              code_reg;
    logic [DATA_W-1:0] value_reg;
    logic              last_reg;

    logic [SP_W-1:0]   sp_m1;
    logic [SP_W-1:0]   sp_m2;
    logic [AW-1:0]     rd_addr;
    logic [AW-1:0]     wr_addr;
    logic [DATA_W-1:0] wr_data;
    logic [DATA_W-1:0] ev;
    logic [DATA_W-1:0] y_mag;
    logic              alu_done;
    logic [DATA_W-1:0] alu_res;

    assign sp_m1 = sp_reg - SP_W'(1);
    assign sp_m2 = sp_reg - SP_W'(2);
    assign y_mag = y_reg[DATA_W-1] ? DATA_W'(-y_reg) : y_reg;

    always_comb
    begin
        case (cmd.rd_sel)
            ADDR_SP:     rd_addr = sp_reg[AW-1:0];
            ADDR_TOP:    rd_addr = sp_m1[AW-1:0];
            ADDR_SECOND: rd_addr = sp_m2[AW-1:0];
            default:     rd_addr = idx_reg;
        endcase
        case (cmd.wr_sel)
            ADDR_SP:     wr_addr = sp_reg[AW-1:0];
            ADDR_TOP:    wr_addr = sp_m1[AW-1:0];
            ADDR_SECOND: wr_addr = sp_m2[AW-1:0];
            default:     wr_addr = idx_reg;
        endcase
        case (cmd.wd_sel)
            WD_OPERAND: wr_data = operand_reg;
            WD_RDATA:   wr_data = rdata_reg;
            WD_X:       wr_data = x_reg;
            default:    wr_data = alu_res;
        endcase
        case (cmd.ev_sel)
            EV_RDATA: ev = rdata_reg;
            EV_Y:     ev = y_reg;
            default:  ev = '0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mem_we)
            mem[wr_addr] <= wr_data;
        if (cmd.mem_re)
            rdata_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sp_reg        <= '0;
            sup_reg       <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            case (cmd.sp_op)
                SP_INC:  sp_reg <= sp_reg + SP_W'(1);
                SP_DEC:  sp_reg <= sp_m1;
                SP_CLR:  sp_reg <= '0;
                default: sp_reg <= sp_reg;
            endcase
            case (cmd.sup_op)
                SUP_SET: sup_reg <= 1'b1;
                SUP_CLR: sup_reg <= 1'b0;
                default: sup_reg <= sup_reg;
            endcase
            if (cmd.idx_clr)
                idx_reg <= '0;
            else if (cmd.idx_inc)
                idx_reg <= idx_reg + AW'(1);
            if (cmd.emit)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
            operand_reg <= operand_value;
        if (cmd.ld_x)
            x_reg <= rdata_reg;
        else if (cmd.clr_x)
            x_reg <= '0;
        if (cmd.ld_y)
            y_reg <= rdata_reg;
        else if (cmd.clr_y)
            y_reg <= '0;
        if (cmd.emit)
        begin
            kind_reg  <= cmd.kind;
            code_reg  <= cmd.code;
            value_reg <= ev;
            last_reg  <= cmd.last;
        end
    end

    rpnc_alu #(
        .FRAC_BITS (FRAC_BITS)
    ) u_alu (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (cmd.alu_start),
        .op     (cmd.alu_op),
        .x      (x_reg),
        .y      (y_reg),
        .done   (alu_done),
        .result (alu_res)
    );

    always_comb
    begin
        st.sp_zero    = (sp_reg == '0);
        st.sp_full    = (sp_reg == SP_W'(STACK_DEPTH));
        st.sp_gt1     = (sp_reg > SP_W'(1));
        st.sup        = sup_reg;
        st.y_zero     = (y_reg == '0);
        st.y_int_zero = ((y_mag >> FRAC_BITS) == '0);
        st.out_busy   = out_valid_reg && !out_ready;
        st.alu_done   = alu_done;
        // A dump ends at the top entry or at the result limit.
        st.idx_last   = (SP_W'(idx_reg) == sp_m1) || (32'(idx_reg) == MAX_RESULTS - 1);
    end

    assign out_valid    = out_valid_reg;
    assign result_kind  = kind_reg;
    assign error_code   = code_reg;
    assign result_value = value_reg;
    assign last_of_run  = last_reg;

endmodule

// ----- rtl/core/rpn_stack_calculator_unit.sv -----
// ----------------------------------------------------------------------------
// rpn_stack_calculator_unit
// Reverse Polish stack calculator on signed fixed-point values.
// ----------------------------------------------------------------------------
// Channel  Handshake             Payload
// in       in_valid / in_ready   req_type, operand_value
// out      out_valid / out_ready result_kind, error_code, result_value,
//                                last_of_run
//
// One item is worked on at a time; the next is accepted only once the sequencer
// is idle again. Divide and remainder use the divider, which retires one quotient
// bit per cycle. A dump reads each entry through the single stack memory read
// port before emitting it. Reset empties the stack; memory contents are not
// cleared. A stalled output holds the sequencer only when a new result must be
// loaded.
// ----------------------------------------------------------------------------
module rpn_stack_calculator_unit
    import rpnc_pkg::*;
#(
    parameter int STACK_DEPTH = 64,
    parameter int FRAC_BITS   = 16
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic        [3:0]        req_type,
    input  logic signed [DATA_W-1:0] operand_value,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic        [2:0]        result_kind,
    output logic        [2:0]        error_code,
    output logic signed [DATA_W-1:0] result_value,
    output logic                     last_of_run
);

    dp_cmd_t    cmd;
    dp_status_t st;

    rpnc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .req_type (req_type),
        .st       (st),
        .cmd      (cmd)
    );

    rpnc_datapath #(
        .STACK_DEPTH (STACK_DEPTH),
        .FRAC_BITS   (FRAC_BITS)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .st            (st),
        .operand_value (operand_value),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .result_kind   (result_kind),
        .error_code    (error_code),
        .result_value  (result_value),
        .last_of_run   (last_of_run)
    );

endmodule

// ----- rtl/core/rpnc_checker.sv -----
// ----------------------------------------------------------------------------
// rpnc_checker
// Port-level checks on the calculator, bound to the top level.
// ----------------------------------------------------------------------------
`include "rpn_stack_calculator_unit_defines.svh"

module rpnc_checker
    import rpnc_pkg::*;
(
    input logic                     clk,
    input logic                     rst_n,
    input logic                     in_valid,
    input logic                     in_ready,
    input logic        [3:0]        req_type,
    input logic signed [DATA_W-1:0] operand_value,
    input logic                     out_valid,
    input logic                     out_ready,
    input logic        [2:0]        result_kind,
    input logic        [2:0]        error_code,
    input logic signed [DATA_W-1:0] result_value,
    input logic                     last_of_run
);

    // An error result carries a code and no value.
    `RPNC_ASSERT_IMP(a_err_fields, clk, rst_n, out_valid && result_kind == KIND_ERROR, result_value == '0 && error_code != ERR_NONE)

    // Only error results carry a code.
    `RPNC_ASSERT_IMP(a_code_only_err, clk, rst_n, out_valid && result_kind != KIND_ERROR, error_code == ERR_NONE)

    // The empty dump marker is always the only result of its item.
    `RPNC_ASSERT_IMP(a_empty_last, clk, rst_n, out_valid && result_kind == KIND_EMPTY, last_of_run && result_value == '0)

    // The sequencer takes one item at a time.
    `RPNC_ASSERT_NXT(a_one_item, clk, rst_n, in_valid && in_ready, !in_ready)

    `RPNC_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(result_value) && $stable(last_of_run))

endmodule

bind rpn_stack_calculator_unit rpnc_checker u_rpnc_checker (.*);

// ----- tb/rpn_stack_calculator_unit_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpn_stack_calculator_unit_checker
// Watches both channels of the stack calculator, keeps a shadow stack, works
// out the results of each accepted command and compares them in order.
// ----------------------------------------------------------------------------
module rpn_stack_calculator_unit_checker
    import rpnc_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    input  logic                     in_ready,
    input  logic        [3:0]        req_type,
    input  logic signed [DATA_W-1:0] operand_value,
    input  logic                     out_valid,
    input  logic                     out_ready,
    input  logic        [2:0]        result_kind,
    input  logic        [2:0]        error_code,
    input  logic signed [DATA_W-1:0] result_value,
    input  logic                     last_of_run,
    output int                       fail_count,
    output int                       pending_count,
    output int                       result_count
);

    localparam int DEPTH = 64;
    localparam int FRAC  = 16;

    typedef struct packed {
        logic [2:0]        kind;
        logic [2:0]        code;
        logic [DATA_W-1:0] value;
        logic              last;
    } calc_result_t;

    calc_result_t      expected_results[$];
    calc_result_t      step_results[$];
    logic [DATA_W-1:0] shadow_stack[DEPTH];
    int                depth_count;
    logic              skip_line_pop;

    function automatic logic signed [DATA_W-1:0] saturate(logic signed [129:0] v);
        if (v > 130'sh7FFF_FFFF_FFFF) return VAL_MAX;
        if (v < -130'sh8000_0000_0000) return VAL_MIN;
        return v[DATA_W-1:0];
    endfunction

    task automatic note(kind_t k, err_t c, logic [DATA_W-1:0] v);
        if (step_results.size() < MAX_RESULTS)
            step_results.push_back('{k, c, v, 1'b0});
    endtask

    task automatic pop_entry(output logic signed [DATA_W-1:0] v);
        if (depth_count > 0) begin
            depth_count--;
            v = shadow_stack[depth_count];
        end
        else begin
            note(KIND_ERROR, ERR_EMPTY, '0);
            v = '0;
        end
    endtask

    task automatic push_entry(logic [DATA_W-1:0] v);
        if (depth_count < DEPTH) begin
            shadow_stack[depth_count] = v;
            depth_count++;
        end
        else
            note(KIND_ERROR, ERR_FULL, '0);
    endtask

    task automatic run_command(logic [3:0] op, logic signed [DATA_W-1:0] operand);
        logic signed [DATA_W-1:0] lhs, rhs;
        logic signed [129:0] wide;
        logic [DATA_W-1:0] ia, ib;
        step_results.delete();
        case (op)
            REQ_PUSH: push_entry(operand);
            REQ_ADD, REQ_SUB, REQ_MUL:
            begin
                pop_entry(rhs);
                pop_entry(lhs);
                if (op == REQ_ADD) wide = 130'(lhs) + 130'(rhs);
                else if (op == REQ_SUB) wide = 130'(lhs) - 130'(rhs);
                else wide = (130'(lhs) * 130'(rhs)) / (130'sd1 << FRAC);
                push_entry(saturate(wide));
            end
            REQ_DIV:
            begin
                pop_entry(rhs);
                if (rhs == 0) note(KIND_ERROR, ERR_ZERO_DIV, '0);
                else
                begin
                    pop_entry(lhs);
                    // Signed division truncates toward zero, as required.
                    wide = (130'(lhs) <<< FRAC) / 130'(rhs);
                    push_entry(saturate(wide));
                end
            end
            REQ_REM:
            begin
                pop_entry(rhs);
                ib = (rhs < 0 ? -rhs : rhs) >> FRAC;
                if (ib == 0) note(KIND_ERROR, ERR_ZERO_DIV, '0);
                else
                begin
                    pop_entry(lhs);
                    ia = (lhs < 0 ? -lhs : lhs) >> FRAC;
                    ia = (ia % ib) << FRAC;
                    push_entry(lhs < 0 ? -ia : ia);
                end
            end
            REQ_ENDLINE:
            begin
                if (!skip_line_pop)
                begin
                    pop_entry(lhs);
                    note(KIND_LINE, ERR_NONE, lhs);
                end
                skip_line_pop = 1'b0;
            end
            REQ_PEEK:
            begin
                if (depth_count > 0)
                    note(KIND_PEEK, ERR_NONE, shadow_stack[depth_count-1]);
                else note(KIND_ERROR, ERR_EMPTY, '0);
                skip_line_pop = 1'b1;
            end
            REQ_DUP:
            begin
                if (depth_count == 0) note(KIND_ERROR, ERR_EMPTY, '0);
                else if (depth_count >= DEPTH) note(KIND_ERROR, ERR_FULL, '0);
                else
                begin
                    shadow_stack[depth_count] = shadow_stack[depth_count-1];
                    depth_count++;
                end
                skip_line_pop = 1'b1;
            end
            REQ_SWAP:
            begin
                if (depth_count > 1)
                begin
                    lhs = shadow_stack[depth_count-1];
                    shadow_stack[depth_count-1] = shadow_stack[depth_count-2];
                    shadow_stack[depth_count-2] = lhs;
                end
                else note(KIND_ERROR, ERR_FEW, '0);
                skip_line_pop = 1'b1;
            end
            REQ_CLEAR:
            begin
                depth_count = 0;
                skip_line_pop = 1'b1;
            end
            REQ_DUMP:
            begin
                if (depth_count == 0) note(KIND_EMPTY, ERR_NONE, '0);
                for (int i = 0; i < depth_count; i++)
                    note(KIND_DUMP, ERR_NONE, shadow_stack[i]);
                skip_line_pop = 1'b1;
            end
            default: note(KIND_ERROR, ERR_UNKNOWN, '0);
        endcase
        if (step_results.size() > 0) step_results[step_results.size()-1].last = 1'b1;
        foreach (step_results[i]) expected_results.push_back(step_results[i]);
    endtask

    assign pending_count = expected_results.size();

    always @(posedge clk or negedge rst_n)
    begin
        calc_result_t want;
        if (!rst_n)
        begin
            depth_count   = 0;
            skip_line_pop = 1'b0;
            fail_count    = 0;
            result_count  = 0;
            expected_results.delete();
        end
        else
        begin
            if (in_valid && in_ready) run_command(req_type, operand_value);
            if (out_valid && out_ready)
            begin
                result_count++;
                if (expected_results.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("Unexpected result item: kind %0d code %0d value %0d",
                                 result_kind, error_code, result_value);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (want.kind !== result_kind || want.code !== error_code ||
                        want.value !== result_value || want.last !== last_of_run)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("Mismatch: expected kind %0d code %0d value %0d last %0d, got kind %0d code %0d value %0d last %0d",
                                     want.kind, want.code, $signed(want.value), want.last,
                                     result_kind, error_code, result_value, last_of_run);
                    end
                end
            end
        end
    end

endmodule

// ----- tb/rpn_stack_calculator_unit_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpn_stack_calculator_unit_tb
// Drives directed and random command streams into the stack calculator under
// several idling patterns and reports the verdict from the checker.
// ----------------------------------------------------------------------------
module rpn_stack_calculator_unit_tb;
    import rpnc_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;

    logic                     clk;
    logic                     rst_n;
    logic                     in_valid;
    logic                     in_ready;
    logic        [3:0]        req_type;
    logic signed [DATA_W-1:0] operand_value;
    logic                     out_valid;
    logic                     out_ready;
    logic        [2:0]        result_kind;
    logic        [2:0]        error_code;
    logic signed [DATA_W-1:0] result_value;
    logic                     last_of_run;
    int                       fail_count;
    int                       pending_count;
    int                       result_count;
    int                       send_idle_pct;
    int                       stall_pct;
    logic                     hold_off;
    int                       idle_cycles;
    int                       command_count;

    rpn_stack_calculator_unit i_dut (.*);

    rpn_stack_calculator_unit_checker i_checker (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Receiver stalls at the set rate, or fully during a hold-off.
    always @(posedge clk)
        out_ready <= !hold_off && ($urandom_range(99) >= stall_pct);

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Watchdog expired with %0d results outstanding", pending_count);
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Valid stays high after acceptance until the next idle cycle or the end
    // of a phase, so that back-to-back items need one assignment per edge.
    task automatic send_command(logic [3:0] op, logic [DATA_W-1:0] operand);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid      <= 1'b1;
        req_type      <= op;
        operand_value <= operand;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        command_count++;
    endtask

    function automatic logic [DATA_W-1:0] random_value();
        case ($urandom_range(5))
            0: return {$urandom, $urandom} & 48'hFFFF_FFFF_FFFF;
            1: return $urandom_range(1, 3) == 1 ? VAL_MAX : VAL_MIN;
            2: return 48'($signed($urandom_range(0, 40)) - 20) <<< 16;
            3: return 48'($signed($urandom_range(0, 2000000)) - 1000000);
            default: return 48'($signed({$urandom} % 32'h0100_0000) - 32'sh0080_0000) <<< 8;
        endcase
    endfunction

    task automatic random_phase(int count);
        int r;
        logic [3:0] op;
        repeat (count)
        begin
            r = $urandom_range(99);
            if (r < 35) op = REQ_PUSH;
            else if (r < 70) op = 4'($urandom_range(REQ_ADD, REQ_REM));
            else if (r < 82) op = REQ_ENDLINE;
            else if (r < 95) op = 4'($urandom_range(REQ_PEEK, REQ_DUMP));
            else op = 4'($urandom_range(REQ_PUSH, 15));
            // Keep full dumps rare so the run stays short.
            if (op == REQ_DUMP && $urandom_range(3) != 0) op = REQ_PEEK;
            send_command(op, random_value());
        end
        in_valid <= 1'b0;
        while (pending_count != 0) @(posedge clk);
        repeat (120) @(posedge clk);
    endtask

    initial
    begin
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        req_type      = REQ_PUSH;
        operand_value = '0;
        out_ready     = 1'b0;
        hold_off      = 1'b0;
        idle_cycles   = 0;
        command_count = 0;
        send_idle_pct = 0;
        stall_pct     = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: errors on an empty stack, then arithmetic at the extremes, swap and dump.
        send_command(REQ_ENDLINE, '0);
        send_command(REQ_DUMP, '0);
        send_command(REQ_PEEK, '0);
        send_command(REQ_DUP, '0);
        send_command(REQ_SWAP, '0);
        send_command(REQ_ADD, '0);
        send_command(4'd15, 48'hFFFF_FFFF_FFFF);
        send_command(REQ_PUSH, VAL_MAX);
        send_command(REQ_PUSH, VAL_MAX);
        send_command(REQ_ADD, '0);
        send_command(REQ_PUSH, VAL_MIN);
        send_command(REQ_MUL, '0);
        send_command(REQ_PUSH, 48'h0000_0000_8000);
        send_command(REQ_DIV, '0);
        send_command(REQ_PUSH, 48'h0000_0000_0000);
        send_command(REQ_DIV, '0);
        send_command(REQ_PUSH, 48'hFFFF_FFFF_8000);
        send_command(REQ_REM, '0);
        send_command(REQ_PUSH, 48'hFFFF_FFF9_0000);
        send_command(REQ_PUSH, 48'h0000_0002_0000);
        send_command(REQ_REM, '0);
        send_command(REQ_SWAP, '0);
        send_command(REQ_SUB, '0);
        send_command(REQ_DUMP, '0);
        send_command(REQ_ENDLINE, '0);
        send_command(REQ_ENDLINE, '0);
        send_command(REQ_CLEAR, '0);

        // Fill the stack past full while the receiver holds off.
        hold_off <= 1'b1;
        fork
            repeat (600) @(posedge clk);
            begin
                repeat (66) send_command(REQ_PUSH, random_value());
                in_valid <= 1'b0;
            end
        join
        hold_off <= 1'b0;
        send_command(REQ_DUP, '0);
        send_command(REQ_DUMP, '0);
        send_command(REQ_CLEAR, '0);

        random_phase(84);
        send_idle_pct = 71;
        random_phase(84);
        send_idle_pct = 0;
        stall_pct     = 71;
        random_phase(84);
        send_idle_pct = 15;
        stall_pct     = 15;
        random_phase(84);

        $display("Sent %0d commands and checked %0d result items", command_count, result_count);
        $display("Phases covered stack overflow, empty pops, saturation and idling on both sides");
        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
